[sv/hopfield_sync_recall_assert.svh]
// ----------------------------------------------------------------------------
// Hopfield recall engine: assertion macros
// Concurrent assertion wrappers for the top-level RTL file of the recall engine.
// They expand to nothing when the code is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef HOPFIELD_SYNC_RECALL_ASSERT_SVH
`define HOPFIELD_SYNC_RECALL_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define HSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hopfield_sync_recall: assertion failed");

// The condition must never be true at a clock edge outside reset.
`define HSR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hopfield_sync_recall: forbidden condition seen");

`else

`define HSR_ASSERT(lbl, clk, rst_n, prop)
`define HSR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[sv/hsr_pkg.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: package
// Command codes, result field constants and the control bundle that drives
// the shared accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsr_pkg;

  // Command codes carried by the cmd field of an input transaction.
  localparam logic [1:0] CMD_WR_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_WR_STATE  = 2'd1;
  localparam logic [1:0] CMD_RUN       = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  // Width and ceiling of the reported change count.
  localparam int unsigned CHG_OUT_W = 7;
  localparam logic [CHG_OUT_W-1:0] CHG_OUT_MAX = 7'd127;

  // Control for one step of the accumulator.
  typedef struct packed {
    logic en;     // a weight and a state bit are present this cycle
    logic first;  // first column of a row: restart the sum
  } acc_ctl_t;

endpackage

[sv/hsr_weight_mem.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: weight memory
// Coupling matrix storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsr_weight_mem #(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned ADDR_W      = 12
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_W-1:0]      waddr_i,
  input  logic [WEIGHT_BITS-1:0] wdata_i,
  input  logic [ADDR_W-1:0]      raddr_i,
  output logic [WEIGHT_BITS-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [WEIGHT_BITS-1:0] mem_q [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/hsr_state_mem.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: neuron state memory
// Two banks of neuron states, one current and one being built by a sweep.
// The bank is the top address bit. One write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsr_state_mem #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic              wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic              rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic mem_q [DEPTH];
  logic rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/hsr_accum.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: shared accumulator
// Adds or subtracts one weight per cycle while enabled, depending on the
// neuron state, and reports the sign decision of the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsr_accum #(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned ACC_W       = 23
) (
  input  logic                          clk_i,
  input  hsr_pkg::acc_ctl_t             ctl_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_i,
  input  logic                          state_i,
  output logic                          new_bit_o
);

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;

  // A +1 state adds the weight, a -1 state subtracts it.
  always_comb begin
    term  = ACC_W'(weight_i);
    base  = ctl_i.first ? '0 : acc_q;
    acc_d = state_i ? (base + term) : (base - term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  // A sum of zero or more gives the +1 state.
  assign new_bit_o = ~acc_d[ACC_W-1];

endmodule

[sv/hopfield_sync_recall.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: top level
// Binary Hopfield network with synchronous update. Transactions load the
// coupling matrix, set neuron states, run sweeps and read states back.
//
//   Channel  | Direction | Handshake                | Payload
//   ---------+-----------+--------------------------+-----------------------
//   input    | in        | in_valid_i / in_stall_o   | cmd, row, col, weight,
//            |           |                          | state_bit
//   result   | out       | out_valid_o / out_stall_i | state_bit_res,
//            |           |                          | changed_count, converged
//   config   | in        | cfg_we_i                  | cfg_wdata_i (sweep count)
//
// During a run, one weight memory read per cycle feeds the single accumulator.
// No transaction is taken while a read or a run is in progress.
// Reset clears control only; weights and states are undefined until written.
// A stalled result holds; the next transaction is taken as it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hopfield_sync_recall #(
  parameter int unsigned NUM_NEURONS = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_wdata_i,
  // Input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic [5:0]              row_i,
  input  logic [5:0]              col_i,
  input  logic signed [15:0]      weight_i,
  input  logic                    state_bit_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    state_bit_res_o,
  output logic [6:0]              changed_count_o,
  output logic                    converged_o
);

`include "hopfield_sync_recall_assert.svh"

  localparam int unsigned IDX_W  = $clog2(NUM_NEURONS);
  localparam int unsigned CNT_W  = $clog2(NUM_NEURONS + 1);
  localparam int unsigned ACC_W  = WEIGHT_BITS + IDX_W + 1;
  localparam int unsigned WADR_W = 2 * IDX_W;
  localparam int unsigned SADR_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_NEURONS - 1);

  // Saturation bounds for incoming weights.
  localparam logic signed [32:0] WMAX = 33'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] WMIN = 33'(-(64'sd1 <<< (WEIGHT_BITS - 1)));

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [7:0]       sweep_cnt_q;
  logic [7:0]       rem_q, rem_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] chg_q, chg_d;
  logic [CNT_W-1:0] chg_next;
  logic [CNT_W-1:0] last_chg_q, last_chg_d;
  logic             rd_ok_q, rd_ok_d;

  // Accumulate stage, aligned with the registered memory reads.
  logic             s1_valid_q;
  logic             s1_first_q;
  logic             s1_last_q;
  logic             s1_self_q;
  logic [IDX_W-1:0] s1_i_q;
  logic             old_i_q, old_i_d;
  logic             old_cur;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic                          out_bit_q;
  logic [hsr_pkg::CHG_OUT_W-1:0] out_cnt_q;
  logic                          out_conv_q;
  logic                          out_load;
  logic                          out_bit_d;

  logic             accept_in;
  logic             row_ok;
  logic             col_ok;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;

  logic signed [32:0]            w_ext;
  logic signed [32:0]            w_sat;
  logic                          w_we;
  logic [WEIGHT_BITS-1:0]        w_rdata;

  logic              s_we;
  logic [SADR_W-1:0] s_waddr;
  logic              s_wdata;
  logic [SADR_W-1:0] s_raddr;
  logic              s_rdata;

  hsr_pkg::acc_ctl_t acc_ctl;
  logic              new_bit;

  // Input handshake and field decode.
  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept_in  = in_valid_i && !in_stall_o;
  assign row_ok     = 32'(row_i) < 32'(NUM_NEURONS);
  assign col_ok     = 32'(col_i) < 32'(NUM_NEURONS);
  assign row_idx    = IDX_W'(row_i);
  assign col_idx    = IDX_W'(col_i);

  // Weight saturation to the stored width.
  always_comb begin
    w_ext = {{17{weight_i[15]}}, weight_i};
    if (w_ext > WMAX) begin
      w_sat = WMAX;
    end else if (w_ext < WMIN) begin
      w_sat = WMIN;
    end else begin
      w_sat = w_ext;
    end
  end

  assign w_we = accept_in && (cmd_i == hsr_pkg::CMD_WR_WEIGHT) && row_ok && col_ok;

  hsr_weight_mem #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ADDR_W      (WADR_W)
  ) u_weight_mem (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i ({row_idx, col_idx}),
    .wdata_i (w_sat[WEIGHT_BITS-1:0]),
    .raddr_i ({i_q, j_q}),
    .rdata_o (w_rdata)
  );

  // State memory ports: the sweep writes the spare bank, commands use the current one.
  always_comb begin
    if (s1_valid_q && s1_last_q) begin
      s_we    = 1'b1;
      s_waddr = {~bank_q, s1_i_q};
      s_wdata = new_bit;
    end else begin
      s_we    = accept_in && (cmd_i == hsr_pkg::CMD_WR_STATE) && row_ok;
      s_waddr = {bank_q, row_idx};
      s_wdata = state_bit_i;
    end
    s_raddr = (state_q == ST_RUN) ? {bank_q, j_q} : {bank_q, row_idx};
  end

  hsr_state_mem #(
    .ADDR_W (SADR_W)
  ) u_state_mem (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Shared accumulator.
  assign acc_ctl.en    = s1_valid_q;
  assign acc_ctl.first = s1_first_q;

  hsr_accum #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ACC_W       (ACC_W)
  ) u_accum (
    .clk_i     (clk_i),
    .ctl_i     (acc_ctl),
    .weight_i  (w_rdata),
    .state_i   (s_rdata),
    .new_bit_o (new_bit)
  );

  // The old state of the row being summed is seen when the column meets the row.
  always_comb begin
    old_cur = s1_self_q ? s_rdata : old_i_q;
    old_i_d = (s1_valid_q && s1_self_q) ? s_rdata : old_i_q;
    chg_next = chg_q;
    if (s1_valid_q && s1_last_q && (new_bit != old_cur)) begin
      chg_next = chg_q + CNT_W'(1);
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    i_d        = i_q;
    j_d        = j_q;
    bank_d     = bank_q;
    chg_d      = chg_next;
    last_chg_d = last_chg_q;
    rd_ok_d    = rd_ok_q;
    out_load   = 1'b0;
    out_bit_d  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          unique case (cmd_i)
            hsr_pkg::CMD_WR_WEIGHT,
            hsr_pkg::CMD_WR_STATE: begin
              out_load = 1'b1;
            end
            hsr_pkg::CMD_READ: begin
              rd_ok_d = row_ok;
              state_d = ST_READ;
            end
            hsr_pkg::CMD_RUN: begin
              rem_d = sweep_cnt_q;
              i_d   = '0;
              j_d   = '0;
              chg_d = '0;
              state_d = (sweep_cnt_q == 8'd0) ? ST_DONE : ST_RUN;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        out_bit_d = rd_ok_q & s_rdata;
        state_d   = ST_IDLE;
      end
      ST_RUN: begin
        if (j_q == IDX_LAST) begin
          j_d = '0;
          if (i_q == IDX_LAST) begin
            i_d     = '0;
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // Last row lands in the spare bank; the banks swap.
        last_chg_d = chg_next;
        chg_d      = '0;
        bank_d     = ~bank_q;
        rem_d      = rem_q - 8'd1;
        state_d    = (rem_q == 8'd1) ? ST_DONE : ST_RUN;
      end
      ST_DONE: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sweep_cnt_q <= 8'd1;
      rem_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      bank_q      <= 1'b0;
      chg_q       <= '0;
      last_chg_q  <= '0;
      rd_ok_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_self_q   <= 1'b0;
      s1_i_q      <= '0;
      old_i_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        sweep_cnt_q <= cfg_wdata_i;
      end
      rem_q       <= rem_d;
      i_q         <= i_d;
      j_q         <= j_d;
      bank_q      <= bank_d;
      chg_q       <= chg_d;
      last_chg_q  <= last_chg_d;
      rd_ok_q     <= rd_ok_d;
      s1_valid_q  <= (state_q == ST_RUN);
      s1_first_q  <= (j_q == '0);
      s1_last_q   <= (j_q == IDX_LAST);
      s1_self_q   <= (j_q == i_q);
      s1_i_q      <= i_q;
      old_i_q     <= old_i_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bit_q  <= out_bit_d;
      out_conv_q <= (last_chg_q == '0);
      if (32'(last_chg_q) > 32'(hsr_pkg::CHG_OUT_MAX)) begin
        out_cnt_q <= hsr_pkg::CHG_OUT_MAX;
      end else begin
        out_cnt_q <= hsr_pkg::CHG_OUT_W'(last_chg_q);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign state_bit_res_o = out_bit_q;
  assign changed_count_o = out_cnt_q;
  assign converged_o     = out_conv_q;

  // Checks on the sequencer and the sweep datapath.
  `HSR_ASSERT(a_done_gives_result, clk_i, rst_ni, (state_q == ST_DONE) |=> out_valid_q)
  `HSR_ASSERT(a_stage_only_in_run, clk_i, rst_ni, s1_valid_q |-> (state_q == ST_RUN || state_q == ST_DRAIN))
  `HSR_ASSERT(a_drain_has_last_col, clk_i, rst_ni, (state_q == ST_DRAIN) |-> (s1_valid_q && s1_last_q))
  `HSR_ASSERT(a_conv_matches_count, clk_i, rst_ni, out_valid_q |-> (out_conv_q == (out_cnt_q == '0)))
  `HSR_ASSERT_NEVER(a_chg_in_range, clk_i, rst_ni, 32'(last_chg_q) > 32'(NUM_NEURONS))

endmodule

[sim/hopfield_sync_recall_tb.sv]
// ----------------------------------------------------------------------------
// Hopfield recall engine: testbench
// Drives weight loads, state writes, sweep runs and state reads into the
// recall engine and checks every result transaction against a behavioral
// predictor of the network, or a typed expectation in some directed rows.
// A short directed table comes first, then a full matrix load, then three
// random phases with different sweep counts and channel idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hopfield_sync_recall_tb;

  localparam int N_NRN = 64;
  localparam int N_PLAN = 22;
  localparam int ITEMS_PER_PHASE = 134;
  localparam int HOLD_CYCLES = 300;

  // One input transaction and one result transaction.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] wt;
    logic               sbit;
  } hop_item_t;

  typedef struct packed {
    logic       sbit;
    logic [6:0] chg;
    logic       conv;
  } recall_res_t;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    K_ITEM,
    K_CFG,
    K_LOAD
  } plan_kind_e;

  typedef struct {
    plan_kind_e         kind;
    logic [1:0]         cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] wt;
    logic               sbit;
    logic [7:0]         cfg_val;
    bit                 typed;
    logic               e_bit;
    logic [6:0]         e_chg;
    logic               e_conv;
  } plan_row_t;

  // Block ports.
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [7:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic [5:0]         row_i;
  logic [5:0]         col_i;
  logic signed [15:0] weight_i;
  logic               state_bit_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               state_bit_res_o;
  logic [6:0]         changed_count_o;
  logic               converged_o;

  // Predictor state: coupling matrix, neuron states, last change count.
  logic signed [15:0] wt_mem [0:N_NRN-1][0:N_NRN-1];
  bit [N_NRN-1:0]     nrn_state;
  int unsigned        flips_last;
  bit [7:0]           sweeps_cfg;

  recall_res_t        recall_q [$];
  recall_res_t        want_res;
  plan_row_t          plan [0:N_PLAN-1];
  int                 err_cnt = 0;
  int unsigned        snd_idle = 11;
  int unsigned        rcv_idle = 86;
  bit                 hold_req = 1'b0;

  hopfield_sync_recall dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .weight_i        (weight_i),
    .state_bit_i     (state_bit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .state_bit_res_o (state_bit_res_o),
    .changed_count_o (changed_count_o),
    .converged_o     (converged_o)
  );

  // Clock with a 12 ns period.
  always #6 clk_i = ~clk_i;

  // One synchronous sweep: all new states come from the old ones.
  function automatic void do_sweep();
    bit [N_NRN-1:0] nxt;
    int unsigned    flips;
    longint         acc;
    flips = 0;
    for (int i = 0; i < N_NRN; i++) begin
      acc = 0;
      for (int j = 0; j < N_NRN; j++) begin
        acc += nrn_state[j] ? longint'(wt_mem[i][j]) : -longint'(wt_mem[i][j]);
      end
      nxt[i] = (acc >= 0);
      if (nxt[i] != nrn_state[i]) flips++;
    end
    nrn_state  = nxt;
    flips_last = flips;
  endfunction

  // Apply one transaction to the network and return its result.
  function automatic recall_res_t hopfield_predict(hop_item_t it);
    recall_res_t r;
    r.sbit = 1'b0;
    case (it.cmd)
      hsr_pkg::CMD_WR_WEIGHT: wt_mem[it.row][it.col] = it.wt;
      hsr_pkg::CMD_WR_STATE:  nrn_state[it.row] = it.sbit;
      hsr_pkg::CMD_RUN: begin
        for (int k = 0; k < sweeps_cfg; k++) do_sweep();
      end
      default:                r.sbit = nrn_state[it.row];
    endcase
    r.chg  = (flips_last > 127) ? hsr_pkg::CHG_OUT_MAX : flips_last[6:0];
    r.conv = (flips_last == 0);
    return r;
  endfunction

  // Offer one transaction, wait for acceptance and queue its expected result.
  task automatic send_txn(input hop_item_t it, input bit typed, input recall_res_t typed_res);
    recall_res_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= it.cmd;
    row_i       <= it.row;
    col_i       <= it.col;
    weight_i    <= it.wt;
    state_bit_i <= it.sbit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = hopfield_predict(it);
    recall_q.push_back(typed ? typed_res : pred);
  endtask

  // Drop valid and wait until every expected result has drained.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (recall_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the sweep count register; the block is idle here.
  task automatic write_sweeps(input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sweeps_cfg = val;
  endtask

  // Load a Hebbian matrix of two random patterns, then a noisy probe state.
  task automatic load_network();
    bit [N_NRN-1:0] pat_a;
    bit [N_NRN-1:0] pat_b;
    int             scale;
    int             wv;
    hop_item_t      it;
    pat_a = {$urandom, $urandom};
    pat_b = {$urandom, $urandom};
    scale = int'($urandom_range(400, 1));
    for (int i = 0; i < N_NRN; i++) begin
      for (int j = 0; j < N_NRN; j++) begin
        wv = 0;
        if (i != j) begin
          wv = ((pat_a[i] == pat_a[j]) ? scale : -scale) +
               ((pat_b[i] == pat_b[j]) ? scale : -scale);
        end
        it.cmd  = hsr_pkg::CMD_WR_WEIGHT;
        it.row  = i[5:0];
        it.col  = j[5:0];
        it.wt   = wv[15:0];
        it.sbit = 1'($urandom_range(1));
        send_txn(it, 1'b0, '0);
      end
    end
    for (int i = 0; i < N_NRN; i++) begin
      it.cmd  = hsr_pkg::CMD_WR_STATE;
      it.row  = i[5:0];
      it.col  = 6'($urandom_range(63));
      it.wt   = 16'($urandom);
      it.sbit = pat_a[i] ^ ($urandom_range(99) < 12);
      send_txn(it, 1'b0, '0);
    end
  endtask

  // Random transaction: mostly writes and reads, a few runs.
  function automatic hop_item_t make_random_item();
    hop_item_t   it;
    int unsigned pick;
    pick    = $urandom_range(99);
    it.row  = 6'($urandom_range(63));
    it.col  = 6'($urandom_range(63));
    it.wt   = 16'($urandom);
    it.sbit = 1'($urandom_range(1));
    if (pick < 35) begin
      it.cmd = hsr_pkg::CMD_WR_WEIGHT;
      case ($urandom_range(7))
        0:       it.wt = 16'sh7FFF;
        1:       it.wt = 16'sh8000;
        2:       it.wt = 16'sh0000;
        default: it.wt = 16'($urandom);
      endcase
    end else if (pick < 60) begin
      it.cmd = hsr_pkg::CMD_WR_STATE;
    end else if (pick < 96) begin
      it.cmd = hsr_pkg::CMD_READ;
    end else begin
      it.cmd = hsr_pkg::CMD_RUN;
    end
    return it;
  endfunction

  // Directed table; typed expectations only where they are obvious.
  initial begin
    plan[0]  = '{K_ITEM, hsr_pkg::CMD_WR_STATE,  6'd0,  6'd0,  16'sh0000, 1'b1, 8'd0,
                 1, 0, 0, 1};
    plan[1]  = '{K_ITEM, hsr_pkg::CMD_WR_STATE,  6'd63, 6'd63, 16'shFFFF, 1'b0, 8'd0,
                 1, 0, 0, 1};
    plan[2]  = '{K_ITEM, hsr_pkg::CMD_READ,      6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 1, 1, 0, 1};
    plan[3]  = '{K_ITEM, hsr_pkg::CMD_READ,      6'd63, 6'd0,  16'sh0000, 1'b1, 8'd0,
                 1, 0, 0, 1};
    plan[4]  = '{K_ITEM, hsr_pkg::CMD_WR_WEIGHT, 6'd63, 6'd63, 16'sh8000, 1'b0, 8'd0,
                 1, 0, 0, 1};
    plan[5]  = '{K_ITEM, hsr_pkg::CMD_WR_WEIGHT, 6'd0,  6'd0,  16'sh7FFF, 1'b1, 8'd0,
                 1, 0, 0, 1};
    plan[6]  = '{K_ITEM, hsr_pkg::CMD_WR_WEIGHT, 6'd0,  6'd63, 16'sh5555, 1'b0, 8'd0,
                 1, 0, 0, 1};
    plan[7]  = '{K_ITEM, hsr_pkg::CMD_WR_WEIGHT, 6'd63, 6'd0,  16'shAAAA, 1'b1, 8'd0,
                 1, 0, 0, 1};
    plan[8]  = '{K_ITEM, hsr_pkg::CMD_WR_STATE,  6'd0,  6'd42, 16'sh1234, 1'b0, 8'd0,
                 1, 0, 0, 1};
    plan[9]  = '{K_ITEM, hsr_pkg::CMD_READ,      6'd0,  6'd21, 16'sh0000, 1'b1, 8'd0,
                 1, 0, 0, 1};
    plan[10] = '{K_LOAD, hsr_pkg::CMD_READ,      6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    // The first run uses the sweep count left by reset.
    plan[11] = '{K_ITEM, hsr_pkg::CMD_RUN,       6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[12] = '{K_ITEM, hsr_pkg::CMD_READ,      6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[13] = '{K_ITEM, hsr_pkg::CMD_READ,      6'd63, 6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    // A zero sweep count makes a run change nothing.
    plan[14] = '{K_CFG,  hsr_pkg::CMD_RUN,       6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[15] = '{K_ITEM, hsr_pkg::CMD_RUN,       6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[16] = '{K_CFG,  hsr_pkg::CMD_RUN,       6'd0,  6'd0,  16'sh0000, 1'b0, 8'd255,
                 0, 0, 0, 0};
    plan[17] = '{K_ITEM, hsr_pkg::CMD_RUN,       6'd0,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[18] = '{K_ITEM, hsr_pkg::CMD_READ,      6'd31, 6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[19] = '{K_ITEM, hsr_pkg::CMD_WR_STATE,  6'd5,  6'd0,  16'sh0000, 1'b1, 8'd0,
                 0, 0, 0, 0};
    plan[20] = '{K_ITEM, hsr_pkg::CMD_READ,      6'd5,  6'd0,  16'sh0000, 1'b0, 8'd0,
                 0, 0, 0, 0};
    plan[21] = '{K_ITEM, hsr_pkg::CMD_WR_WEIGHT, 6'd10, 6'd20, 16'shFFFF, 1'b0, 8'd0,
                 0, 0, 0, 0};
  end

  // Main sequence: reset, directed table, then three random phases.
  initial begin : main_seq
    hop_item_t   it;
    recall_res_t tres;
    bit [7:0]    phase_sweeps [0:2];
    phase_sweeps = '{8'd1, 8'd2, 8'd3};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'd0;
    in_valid_i  = 1'b0;
    cmd_i       = hsr_pkg::CMD_WR_WEIGHT;
    row_i       = 6'd0;
    col_i       = 6'd0;
    weight_i    = 16'sh0000;
    state_bit_i = 1'b0;
    nrn_state   = '0;
    flips_last  = 0;
    sweeps_cfg  = 8'd1;
    for (int i = 0; i < N_NRN; i++) begin
      for (int j = 0; j < N_NRN; j++) wt_mem[i][j] = 16'sh0000;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < N_PLAN; n++) begin
      case (plan[n].kind)
        K_CFG: begin
          wait_idle();
          write_sweeps(plan[n].cfg_val);
        end
        K_LOAD: load_network();
        default: begin
          it   = '{plan[n].cmd, plan[n].row, plan[n].col, plan[n].wt, plan[n].sbit};
          tres = '{plan[n].e_bit, plan[n].e_chg, plan[n].e_conv};
          send_txn(it, plan[n].typed, tres);
        end
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      write_sweeps(phase_sweeps[ph]);
      case (ph)
        0: begin
          snd_idle = 11;
          rcv_idle = 86;
        end
        1: begin
          snd_idle = 86;
          rcv_idle = 11;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          hold_req = 1'b1;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_txn(make_random_item(), 1'b0, '0);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stall, plus one long hold-off while the sender runs.
  initial begin : rcv_seq
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (recall_q.size() == 0) begin
        $display("%0t: result with nothing expected: bit %0b count %0d conv %0b",
                 $time, state_bit_res_o, changed_count_o, converged_o);
        err_cnt++;
      end else begin
        want_res = recall_q.pop_front();
        if (state_bit_res_o !== want_res.sbit) begin
          $display("%0t: state_bit_res expected %0b actual %0b",
                   $time, want_res.sbit, state_bit_res_o);
          err_cnt++;
        end
        if (changed_count_o !== want_res.chg) begin
          $display("%0t: changed_count expected %0d actual %0d",
                   $time, want_res.chg, changed_count_o);
          err_cnt++;
        end
        if (converged_o !== want_res.conv) begin
          $display("%0t: converged expected %0b actual %0b",
                   $time, want_res.conv, converged_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(64'd100_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
